/* hdl/bf3_pkg.sv */
// Shared types and constants for the 3x3 RGB box filter.
// No dependencies; every other file of the block but bf3_queue imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bf3_pkg;

  // Fixed port widths.
  localparam int SIZE_W    = 11;
  localparam int PORT_CH_W = 16;

  // Request kinds on the input channel.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam int SIZE_RESET = 64;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QCOUNT_W    = 3;

  // Divisor codes for the mean of 4, 6 or 9 samples.
  typedef logic [1:0] div_code_t;
  localparam div_code_t DIV_4 = 2'd0;
  localparam div_code_t DIV_6 = 2'd1;
  localparam div_code_t DIV_9 = 2'd2;

  // Reciprocals scaled by 2^RECIP_SHIFT; exact for sums of up to 20 bits.
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP_4 = 23'd4194304;
  localparam logic [RECIP_W-1:0] RECIP_3 = 23'd5592406;
  localparam logic [RECIP_W-1:0] RECIP_9 = 23'd1864136;

  // Classification of one pixel position, made by the front.
  typedef struct packed {
    logic      emit;    // at least one result
    logic      two;     // last column: a second result follows
    logic      top_ok;  // row above is inside the image
    logic      bot_ok;  // row below is inside the image
    logic      use_w0;  // column two to the left is inside the image
    div_code_t div1;
    div_code_t div2;
  } item_ctrl_t;

endpackage

`default_nettype wire

/* hdl/bf3_front.sv */
// Front of the box filter: counters, request classification and line buffers.
// Depends on bf3_pkg; feeds the queue that stands before bf3_back.
`timescale 1ns / 1ps
`default_nettype none

module bf3_front #(
  parameter int MAX_SIZE = 1024,
  parameter int CH_BITS  = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [bf3_pkg::SIZE_W-1:0]      cfg_image_size,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             in_req_type,
  input  wire  [bf3_pkg::PORT_CH_W-1:0]   in_red,
  input  wire  [bf3_pkg::PORT_CH_W-1:0]   in_green,
  input  wire  [bf3_pkg::PORT_CH_W-1:0]   in_blue,
  input  wire  [bf3_pkg::QCOUNT_W-1:0]    q_count,
  output logic                            push,
  output bf3_pkg::item_ctrl_t             push_ctrl,
  output logic [3*CH_BITS-1:0]            push_upper,
  output logic [3*CH_BITS-1:0]            push_middle,
  output logic [3*CH_BITS-1:0]            push_bottom
);
  import bf3_pkg::*;

  localparam int AW      = (MAX_SIZE > 2) ? $clog2(MAX_SIZE) : 1;
  localparam int CNT_W   = $clog2(MAX_SIZE + 1);
  localparam int PIX_W   = 3 * CH_BITS;
  localparam int RESET_N = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;

  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] r_r, r_nxt;
  logic [AW-1:0]    c_r, c_nxt;

  logic             accept, drain, ignore, item, c_last;
  logic [PIX_W-1:0] cur;
  item_ctrl_t       ctrl;

  logic             s1_v_r;
  logic             par_r;
  item_ctrl_t       ctrl_r;
  logic [PIX_W-1:0] bot_r;

  // Two line memories; row r is written into the one picked by r's parity,
  // so it overwrites row r-2 while row r-1 stays in the other.
  logic [PIX_W-1:0] line0 [MAX_SIZE];
  logic [PIX_W-1:0] line1 [MAX_SIZE];
  logic [PIX_W-1:0] q0_r, q1_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = ((QCOUNT_W+1)'(q_count) + (QCOUNT_W+1)'(s1_v_r))
                     < (QCOUNT_W+1)'(QUEUE_DEPTH);
  assign accept    = in_valid && in_ready;

  assign drain  = (r_r >= n_r);
  assign ignore = (in_req_type == REQ_DRAIN) && !drain;
  assign item   = accept && !ignore;
  assign c_last = (CNT_W'(c_r) == (n_r - CNT_W'(1)));

  always_comb begin
    if (drain) begin
      cur = '0;
    end else begin
      cur = {in_blue[CH_BITS-1:0], in_green[CH_BITS-1:0], in_red[CH_BITS-1:0]};
    end
  end

  always_comb begin
    ctrl.emit   = (r_r != '0) && (c_r != '0);
    ctrl.two    = ctrl.emit && c_last;
    ctrl.top_ok = (r_r >= CNT_W'(2));
    ctrl.bot_ok = !drain;
    ctrl.use_w0 = (CNT_W'(c_r) >= CNT_W'(2));
    if (ctrl.top_ok && ctrl.bot_ok && ctrl.use_w0) begin
      ctrl.div1 = DIV_9;
    end else if ((ctrl.top_ok && ctrl.bot_ok) || ctrl.use_w0) begin
      ctrl.div1 = DIV_6;
    end else begin
      ctrl.div1 = DIV_4;
    end
    ctrl.div2 = (ctrl.top_ok && ctrl.bot_ok) ? DIV_6 : DIV_4;
  end

  always_comb begin
    n_nxt = n_r;
    r_nxt = r_r;
    c_nxt = c_r;
    if (cfg_valid) begin
      if (cfg_image_size < SIZE_W'(2)) begin
        n_nxt = CNT_W'(2);
      end else if (32'(cfg_image_size) > MAX_SIZE) begin
        n_nxt = CNT_W'(MAX_SIZE);
      end else begin
        n_nxt = CNT_W'(cfg_image_size);
      end
      r_nxt = '0;
      c_nxt = '0;
    end else if (item) begin
      if (c_last) begin
        c_nxt = '0;
        r_nxt = (r_r == n_r) ? '0 : r_r + CNT_W'(1);
      end else begin
        c_nxt = c_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= CNT_W'(RESET_N);
      r_r    <= '0;
      c_r    <= '0;
      s1_v_r <= 1'b0;
    end else begin
      n_r    <= n_nxt;
      r_r    <= r_nxt;
      c_r    <= c_nxt;
      s1_v_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (item) begin
      par_r  <= r_r[0];
      ctrl_r <= ctrl;
      bot_r  <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (item) begin
      q0_r <= line0[c_r];
    end
    if (item && !drain && !r_r[0]) begin
      line0[c_r] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (item) begin
      q1_r <= line1[c_r];
    end
    if (item && !drain && r_r[0]) begin
      line1[c_r] <= cur;
    end
  end

  assign push        = s1_v_r;
  assign push_ctrl   = ctrl_r;
  assign push_upper  = par_r ? q1_r : q0_r;
  assign push_middle = par_r ? q0_r : q1_r;
  assign push_bottom = bot_r;

  a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(c_r) < n_r) && (r_r <= n_r) && (n_r >= CNT_W'(2)))
    else $error("row or column counter outside the image");

  a_queue_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (q_count < QCOUNT_W'(QUEUE_DEPTH)))
    else $error("request pushed toward a full queue");

endmodule

`default_nettype wire

/* hdl/bf3_queue.sv */
// Small register queue that decouples the filter front from the back.
// Depends on nothing but its parameters; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

module bf3_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           push,
  input  wire  [WIDTH-1:0]              push_data,
  input  wire                           pop,
  output logic                          head_valid,
  output logic [WIDTH-1:0]              head_data,
  output logic [$clog2(DEPTH+1)-1:0]    count
);

  localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_pop;

  assign do_pop     = pop && (cnt_r != '0);
  assign head_valid = (cnt_r != '0);
  assign head_data  = slot[rd_r];
  assign count      = cnt_r;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* hdl/bf3_back.sv */
// Back of the box filter: 3x3 window, column sums, reciprocal divide, output.
// Depends on bf3_pkg; takes requests from bf3_queue.
`timescale 1ns / 1ps
`default_nettype none

module bf3_back #(
  parameter int CH_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            head_valid,
  input  wire bf3_pkg::item_ctrl_t       head_ctrl,
  input  wire  [3*CH_BITS-1:0]           head_upper,
  input  wire  [3*CH_BITS-1:0]           head_middle,
  input  wire  [3*CH_BITS-1:0]           head_bottom,
  output logic                           pop,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [bf3_pkg::PORT_CH_W-1:0]  out_red,
  output logic [bf3_pkg::PORT_CH_W-1:0]  out_green,
  output logic [bf3_pkg::PORT_CH_W-1:0]  out_blue,
  output logic                           out_run_last,
  output logic                           out_frame_last
);
  import bf3_pkg::*;

  localparam int PIX_W  = 3 * CH_BITS;
  localparam int SUM_W  = CH_BITS + 4;
  localparam int PROD_W = SUM_W + RECIP_W;

  function automatic logic [SUM_W-1:0] col_sum(input logic [CH_BITS-1:0] t,
                                               input logic [CH_BITS-1:0] m,
                                               input logic [CH_BITS-1:0] b,
                                               input logic top_ok,
                                               input logic bot_ok);
    logic [SUM_W-1:0] s;
    s = SUM_W'(m);
    if (top_ok) s = s + SUM_W'(t);
    if (bot_ok) s = s + SUM_W'(b);
    return s;
  endfunction

  // Truncated mean: multiply by a scaled reciprocal and keep the high bits.
  function automatic logic [CH_BITS-1:0] mean(input logic [SUM_W-1:0] s,
                                              input div_code_t code);
    logic [SUM_W-1:0]   opd;
    logic [RECIP_W-1:0] k;
    logic [PROD_W-1:0]  p;
    unique case (code)
      DIV_6: begin
        opd = s >> 1;
        k   = RECIP_3;
      end
      DIV_9: begin
        opd = s;
        k   = RECIP_9;
      end
      default: begin
        opd = s;
        k   = RECIP_4;
      end
    endcase
    p = PROD_W'(opd) * PROD_W'(k);
    return p[RECIP_SHIFT +: CH_BITS];
  endfunction

  // Window: column c-2 (w0) and column c-1 (w1), each top, middle, bottom.
  logic [PIX_W-1:0] w0_top_r, w0_mid_r, w0_bot_r;
  logic [PIX_W-1:0] w1_top_r, w1_mid_r, w1_bot_r;

  logic [SUM_W-1:0] sum1 [3];
  logic [SUM_W-1:0] sum2 [3];

  logic             b1_v_r, b1_v_nxt;
  item_ctrl_t       b1_ctrl_r;
  logic [SUM_W-1:0] b1_sum1_r [3];
  logic [SUM_W-1:0] b1_sum2_r [3];

  logic               out_v_r, out_v_nxt;
  logic               second_r, second_nxt;
  item_ctrl_t         oc_r;
  logic [CH_BITS-1:0] q1_r [3];
  logic [CH_BITS-1:0] q2_r [3];

  logic out_last, out_free, b1_ready;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum2[k] = col_sum(w1_top_r[k*CH_BITS +: CH_BITS], w1_mid_r[k*CH_BITS +: CH_BITS],
                        w1_bot_r[k*CH_BITS +: CH_BITS], head_ctrl.top_ok, head_ctrl.bot_ok)
              + col_sum(head_upper[k*CH_BITS +: CH_BITS],
                        head_middle[k*CH_BITS +: CH_BITS],
                        head_bottom[k*CH_BITS +: CH_BITS], head_ctrl.top_ok, head_ctrl.bot_ok);
      sum1[k] = sum2[k];
      if (head_ctrl.use_w0) begin
        sum1[k] = sum2[k]
                + col_sum(w0_top_r[k*CH_BITS +: CH_BITS], w0_mid_r[k*CH_BITS +: CH_BITS],
                          w0_bot_r[k*CH_BITS +: CH_BITS], head_ctrl.top_ok,
                          head_ctrl.bot_ok);
      end
    end
  end

  // The output register holds one request's one or two results.
  assign out_last = second_r || !oc_r.two;
  assign out_free = !out_v_r || (out_ready && out_last);
  assign b1_ready = !b1_v_r || out_free;
  assign pop      = head_valid && b1_ready;

  always_comb begin
    b1_v_nxt   = b1_v_r;
    out_v_nxt  = out_v_r;
    second_nxt = second_r;
    if (b1_ready) begin
      b1_v_nxt = pop && head_ctrl.emit;
    end
    if (out_free) begin
      out_v_nxt  = b1_v_r;
      second_nxt = 1'b0;
    end else if (out_ready) begin
      second_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      b1_v_r   <= b1_v_nxt;
      out_v_r  <= out_v_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w0_top_r <= w1_top_r;
      w0_mid_r <= w1_mid_r;
      w0_bot_r <= w1_bot_r;
      w1_top_r <= head_upper;
      w1_mid_r <= head_middle;
      w1_bot_r <= head_bottom;
    end
    if (b1_ready) begin
      b1_ctrl_r <= head_ctrl;
      for (int k = 0; k < 3; k++) begin
        b1_sum1_r[k] <= sum1[k];
        b1_sum2_r[k] <= sum2[k];
      end
    end
    if (out_free) begin
      oc_r <= b1_ctrl_r;
      for (int k = 0; k < 3; k++) begin
        q1_r[k] <= mean(b1_sum1_r[k], b1_ctrl_r.div1);
        q2_r[k] <= mean(b1_sum2_r[k], b1_ctrl_r.div2);
      end
    end
  end

  assign out_valid      = out_v_r;
  assign out_red        = PORT_CH_W'(second_r ? q2_r[0] : q1_r[0]);
  assign out_green      = PORT_CH_W'(second_r ? q2_r[1] : q1_r[1]);
  assign out_blue       = PORT_CH_W'(second_r ? q2_r[2] : q1_r[2]);
  assign out_run_last   = out_last;
  // The bottom row is the only one without a row below it.
  assign out_frame_last = second_r && !oc_r.bot_ok;

  a_second_only_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && second_r) |-> oc_r.two)
    else $error("second result shown for a request that has only one");

  a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_ready && !out_last) |=> (out_v_r && second_r))
    else $error("second result of a row end was lost");

endmodule

`default_nettype wire

/* hdl/box_filter_3x3_rgb_top.sv */
// Top level of the 3x3 RGB box filter: front, queue and back wired together.
// Depends on bf3_pkg, bf3_front, bf3_queue and bf3_back.
//
//   channel   direction   handshake               payload
//   cfg       in          cfg_valid / cfg_ready   cfg_image_size
//   in        in          in_valid / in_ready     in_req_type, in_red, in_green, in_blue
//   out       out         out_valid / out_ready   out_red/green/blue, run_last, frame_last
//
// One request is taken per clock while in_ready is high; a row-end request yields two
// results and holds the output register for both, which the four-entry queue absorbs.
// A request passes the line memory read, the queue, the column sums and the
// reciprocal multiply into the output register, in that order, each registered.
// Reset is synchronous; the line memories are not cleared and need no pass.
// A stalled output fills the queue, and in_ready drops when it has no room.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_3x3_rgb_top #(
  parameter int MAX_SIZE     = 1024,
  parameter int CHANNEL_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [bf3_pkg::SIZE_W-1:0]     cfg_image_size,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire                            in_req_type,
  input  wire  [bf3_pkg::PORT_CH_W-1:0]  in_red,
  input  wire  [bf3_pkg::PORT_CH_W-1:0]  in_green,
  input  wire  [bf3_pkg::PORT_CH_W-1:0]  in_blue,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [bf3_pkg::PORT_CH_W-1:0]  out_red,
  output logic [bf3_pkg::PORT_CH_W-1:0]  out_green,
  output logic [bf3_pkg::PORT_CH_W-1:0]  out_blue,
  output logic                           out_run_last,
  output logic                           out_frame_last
);
  import bf3_pkg::*;

  localparam int PIX_W = 3 * CHANNEL_BITS;
  localparam int Q_W   = $bits(item_ctrl_t) + 3 * PIX_W;

  logic                push, pop, head_valid;
  item_ctrl_t          push_ctrl, head_ctrl;
  logic [PIX_W-1:0]    push_upper, push_middle, push_bottom;
  logic [PIX_W-1:0]    head_upper, head_middle, head_bottom;
  logic [Q_W-1:0]      head_data;
  logic [QCOUNT_W-1:0] q_count;

  bf3_front #(
    .MAX_SIZE (MAX_SIZE),
    .CH_BITS  (CHANNEL_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_image_size (cfg_image_size),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .q_count        (q_count),
    .push           (push),
    .push_ctrl      (push_ctrl),
    .push_upper     (push_upper),
    .push_middle    (push_middle),
    .push_bottom    (push_bottom)
  );

  bf3_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({push_ctrl, push_upper, push_middle, push_bottom}),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .count      (q_count)
  );

  assign {head_ctrl, head_upper, head_middle, head_bottom} = head_data;

  bf3_back #(
    .CH_BITS (CHANNEL_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_ctrl      (head_ctrl),
    .head_upper     (head_upper),
    .head_middle    (head_middle),
    .head_bottom    (head_bottom),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_run_last   (out_run_last),
    .out_frame_last (out_frame_last)
  );

endmodule

`default_nettype wire

/* dv/tb_box_filter_3x3_rgb_top.sv */
// Self-checking testbench for box_filter_3x3_rgb_top: streams square RGB frames,
// predicts every filtered pixel in its own line-buffer model and checks each result.
// Depends on bf3_pkg and the box filter RTL.
`timescale 1ns / 1ps

module tb_box_filter_3x3_rgb_top;
  import bf3_pkg::*;

  localparam int MAX_SIZE       = 1024;
  localparam int CHANNEL_BITS   = 16;
  localparam int TOTAL_ITEMS    = 1150;
  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [PORT_CH_W-1:0] CH_MASK = PORT_CH_W'((1 << CHANNEL_BITS) - 1);

  // One pixel: index 0 is red, 1 is green, 2 is blue.
  typedef logic [2:0][PORT_CH_W-1:0] rgb_t;

  typedef struct packed {
    logic [PORT_CH_W-1:0] red;
    logic [PORT_CH_W-1:0] green;
    logic [PORT_CH_W-1:0] blue;
    logic                 run_last;
    logic                 frame_last;
  } filt_px_t;

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [SIZE_W-1:0]    cfg_image_size = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic                 in_req_type    = REQ_PIXEL;
  logic [PORT_CH_W-1:0] in_red         = '0;
  logic [PORT_CH_W-1:0] in_green       = '0;
  logic [PORT_CH_W-1:0] in_blue        = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [PORT_CH_W-1:0] out_red;
  logic [PORT_CH_W-1:0] out_green;
  logic [PORT_CH_W-1:0] out_blue;
  logic                 out_run_last;
  logic                 out_frame_last;

  box_filter_3x3_rgb_top #(
    .MAX_SIZE    (MAX_SIZE),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_image_size(cfg_image_size),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_run_last  (out_run_last),
    .out_frame_last(out_frame_last)
  );

  // Filter state as the predictor sees it.
  rgb_t              upper_mem [MAX_SIZE];
  rgb_t              middle_mem[MAX_SIZE];
  rgb_t              win[6];
  int unsigned       row_pos;
  int unsigned       col_pos;
  logic [SIZE_W-1:0] size_reg;

  filt_px_t    expected_px[$];
  int unsigned fail_count     = 0;
  int unsigned pixels_checked = 0;
  int unsigned requests_sent  = 0;
  int unsigned frames_done    = 0;
  int unsigned idle_cycles    = 0;
  bit          tx_idle        = 1'b1;
  bit          rx_idle        = 1'b1;
  bit          hold_out_req   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_filter_model();
    for (int i = 0; i < MAX_SIZE; i++) begin
      upper_mem[i]  = '0;
      middle_mem[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
    row_pos  = 0;
    col_pos  = 0;
    size_reg = SIZE_W'(SIZE_RESET);
  endfunction

  // Mean over the previous column (win[3..5]), the current one and, when
  // use_w0 is set, the column two to the left (win[0..2]).
  function automatic filt_px_t average_window(bit use_w0, rgb_t ct, rgb_t cm, rgb_t cb,
                                              bit top_ok, bit bot_ok, bit run_last,
                                              bit frame_last);
    int unsigned sum;
    int unsigned cnt;
    int          ch;
    rgb_t        avg;
    filt_px_t    res;
    cnt = (1 + int'(top_ok) + int'(bot_ok)) * (use_w0 ? 3 : 2);
    for (ch = 0; ch < 3; ch++) begin
      sum = cm[ch] + win[4][ch];
      if (top_ok) sum += ct[ch] + win[3][ch];
      if (bot_ok) sum += cb[ch] + win[5][ch];
      if (use_w0) begin
        sum += win[1][ch];
        if (top_ok) sum += win[0][ch];
        if (bot_ok) sum += win[2][ch];
      end
      avg[ch] = PORT_CH_W'(sum / cnt);
    end
    res.red        = avg[0];
    res.green      = avg[1];
    res.blue       = avg[2];
    res.run_last   = run_last;
    res.frame_last = frame_last;
    return res;
  endfunction

  // Advances the filter state by one accepted request and queues its results.
  function automatic void filter_request(logic kind, rgb_t px);
    int unsigned n;
    int unsigned r;
    int unsigned c;
    bit          drain;
    rgb_t        ct;
    rgb_t        cm;
    rgb_t        cb;
    n = size_reg;
    if (n < 2) n = 2;
    if (n > MAX_SIZE) n = MAX_SIZE;
    r = row_pos;
    c = col_pos;
    drain = (r >= n);
    // A drain request while the image is still coming changes nothing.
    if (kind == REQ_DRAIN && !drain) return;
    if (c >= n) c = n - 1;
    ct = upper_mem[c];
    cm = middle_mem[c];
    if (drain) begin
      cb = '0;
    end else begin
      for (int i = 0; i < 3; i++) cb[i] = px[i] & CH_MASK;
      upper_mem[c]  = middle_mem[c];
      middle_mem[c] = cb;
    end
    if (r >= 1 && c >= 1) begin
      expected_px.push_back(average_window(c >= 2, ct, cm, cb, r >= 2, !drain,
                                           c != n - 1, 1'b0));
      if (c == n - 1)
        expected_px.push_back(average_window(1'b0, ct, cm, cb, r >= 2, !drain,
                                             1'b1, drain));
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = ct;
    win[4] = cm;
    win[5] = cb;
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r > n) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  function automatic logic [PORT_CH_W-1:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PORT_CH_W'($urandom);
    endcase
  endfunction

  function automatic rgb_t pick_pixel();
    rgb_t px;
    for (int i = 0; i < 3; i++) px[i] = pick_channel();
    return px;
  endfunction

  // Offers one request and returns at the edge where it is taken; valid stays
  // high so a back-to-back request needs no extra edge.
  task automatic send_request(logic kind, rgb_t px);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_red      <= px[0];
    in_green    <= px[1];
    in_blue     <= px[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filter_request(kind, px);
    requests_sent++;
  endtask

  // Waits until every predicted result is out and the pipeline has emptied.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] value);
    cfg_valid      <= 1'b1;
    cfg_image_size <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_reg = value;
    row_pos  = 0;
    col_pos  = 0;
  endtask

  task automatic send_frame(int unsigned n, int unsigned stop_after, bit noisy);
    for (int unsigned i = 0; i < n * n && i < stop_after; i++) begin
      if (noisy && $urandom_range(0, 29) == 0) send_request(REQ_DRAIN, pick_pixel());
      send_request(REQ_PIXEL, pick_pixel());
    end
    if (stop_after < n * n) return;
    // Pixel requests in the drain row are treated as drains.
    for (int unsigned i = 0; i < n; i++)
      send_request((noisy && $urandom_range(0, 3) == 0) ? REQ_PIXEL : REQ_DRAIN,
                   pick_pixel());
    frames_done++;
  endtask

  task automatic test_corner_cases();
    rgb_t white;
    rgb_t black;
    white = '1;
    black = '0;
    // A size below two acts as two.
    write_size('0);
    send_request(REQ_DRAIN, white);
    send_request(REQ_PIXEL, white);
    send_request(REQ_PIXEL, black);
    send_request(REQ_PIXEL, {16'hFFFF, 16'h0000, 16'hFFFF});
    send_request(REQ_PIXEL, white);
    send_request(REQ_DRAIN, black);
    send_request(REQ_DRAIN, black);
    frames_done++;
    settle();
    write_size(SIZE_W'(3));
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_request(REQ_DRAIN, white);
      send_request(REQ_PIXEL, (i % 2 == 0) ? white : black);
    end
    send_request(REQ_DRAIN, white);
    send_request(REQ_PIXEL, white);
    send_request(REQ_DRAIN, white);
    frames_done++;
    settle();
  endtask

  // All ones in the register is far above the maximum size and acts as the
  // largest image; one full row and a few pixels of the next are enough.
  task automatic test_size_clamp();
    tx_idle = 1'b0;
    write_size('1);
    repeat (MAX_SIZE + 6) send_request(REQ_PIXEL, pick_pixel());
    settle();
    tx_idle = 1'b1;
  endtask

  task automatic test_back_pressure();
    write_size(SIZE_W'(6));
    tx_idle      = 1'b0;
    hold_out_req = 1'b1;
    send_frame(6, 36, 1'b0);
    settle();
    tx_idle = 1'b1;
  endtask

  // Small random frames fill what is left of the request budget.
  task automatic test_random_frames();
    int unsigned n;
    int unsigned stop_after;
    bit          need_write;
    need_write = 1'b1;
    while (requests_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       n = $urandom_range(9, 12);
        1, 2, 3: n = $urandom_range(5, 8);
        default: n = $urandom_range(2, 4);
      endcase
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (need_write || $urandom_range(0, 2) != 0 || n != size_reg) begin
        settle();
        write_size((n == 2) ? SIZE_W'($urandom_range(0, 2)) : SIZE_W'(n));
      end
      // Now and then a frame is cut short and the next size write restarts it.
      stop_after = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n * n - 1) : n * n;
      send_frame(n, stop_after, 1'b1);
      need_write = (stop_after < n * n);
      if (need_write) settle();
    end
    settle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Result sink: random stalls per result, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned stall;
    forever begin
      if (hold_out_req) begin
        out_ready    <= 1'b0;
        hold_out_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = rx_idle ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    filt_px_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_px.size() == 0) begin
        $error("result with nothing expected: red %0h green %0h blue %0h",
               out_red, out_green, out_blue);
        fail_count++;
      end else begin
        want = expected_px.pop_front();
        check_field("out_red", want.red, out_red);
        check_field("out_green", want.green, out_green);
        check_field("out_blue", want.blue, out_blue);
        check_field("out_run_last", want.run_last, out_run_last);
        check_field("out_frame_last", want.frame_last, out_frame_last);
        pixels_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_px.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_filter_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_cases();
    test_size_clamp();
    test_back_pressure();
    test_random_frames();
    settle();
    if (expected_px.size() != 0) begin
      $error("%0d expected results never arrived", expected_px.size());
      fail_count++;
    end
    $display("Sent %0d requests over %0d complete frames and checked %0d filtered pixels.",
             requests_sent, frames_done, pixels_checked);
    $display("Covered clamped sizes, stray drains, aborted frames and a long output stall.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/bf3_pkg.sv
hdl/bf3_front.sv
hdl/bf3_queue.sv
hdl/bf3_back.sv
hdl/box_filter_3x3_rgb_top.sv
dv/tb_box_filter_3x3_rgb_top.sv
